// File: hw/rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants for the radix text unit
// Register indexes, character limits, reset alphabet and link structs.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int MAX_DIGITS_DEF  = 56;
  localparam int VALUE_WIDTH_DEF = 32;

  // digit_count register width; also the width of a digit index
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CHAR_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FIRST = 3'd1;

  localparam logic [COUNT_W-1:0]    DIGIT_COUNT_RESET = 6'd10;
  localparam logic [CFG_DATA_W-1:0] ALPHA_RESET_0     = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] ALPHA_RESET_1     = 64'h0000_0000_0000_3938;

  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd127;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // carry link between neighbouring cells
  typedef struct packed {
    logic step;
    logic carry;
  } srt_link_t;

  // per-cycle command to every cell of the row
  typedef struct packed {
    logic clear;
    logic shift;
  } srt_cell_ctl_t;

  // alphabet checker status
  typedef struct packed {
    logic busy;
    logic ok;
  } srt_alpha_stat_t;

  // reset value of alphabet byte b
  function automatic logic [CHAR_W-1:0] alpha_reset_byte(input int b);
    logic [CHAR_W-1:0] res;
    res = '0;
    if (b < 8) begin
      res = ALPHA_RESET_0[b*8 +: 8];
    end else if (b < 16) begin
      res = ALPHA_RESET_1[(b-8)*8 +: 8];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/srt_in_if.sv
// ----------------------------------------------------------------------------
// srt_in_if: input channel
// Carries one signed value per beat.
// ----------------------------------------------------------------------------
interface srt_in_if #(
  parameter int VALUE_WIDTH = srt_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: hw/rtl/srt_out_if.sv
// ----------------------------------------------------------------------------
// srt_out_if: result channel
// Carries one text character per beat, with a last flag.
// ----------------------------------------------------------------------------
interface srt_out_if;
  logic                        valid;
  logic                        ready;
  logic [srt_pkg::CHAR_W-1:0]  out_char;
  logic                        last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

// File: hw/rtl/srt_cfg_if.sv
// ----------------------------------------------------------------------------
// srt_cfg_if: configuration write channel
// Carries a register index and write data per beat.
// ----------------------------------------------------------------------------
interface srt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [srt_pkg::CFG_IDX_W-1:0]  index;
  logic [srt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/srt_alpha.sv
// ----------------------------------------------------------------------------
// srt_alpha: alphabet registers and checker
// Holds digit_count and the alphabet bytes, sweeps the alphabet after reset and
// after each write (one character a cycle) and looks up the character of a digit.
// ----------------------------------------------------------------------------
module srt_alpha #(
  parameter int MAX_DIGITS = srt_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr,
  input  logic [srt_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [srt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [srt_pkg::COUNT_W-1:0]      rd_digit,
  output logic [srt_pkg::CHAR_W-1:0]       rd_char,
  output logic [srt_pkg::COUNT_W-1:0]      radix,
  output srt_pkg::srt_alpha_stat_t         stat
);

  localparam int CW = srt_pkg::CHAR_W;

  logic [srt_pkg::COUNT_W-1:0]  count_r,  count_nxt;
  logic [CW*MAX_DIGITS-1:0]     alpha_r,  alpha_nxt;
  logic [srt_pkg::COUNT_W-1:0]  idx_r,    idx_nxt;
  logic [127:0]                 seen_r,   seen_nxt;
  logic                         busy_r,   busy_nxt;
  logic                         ok_r,     ok_nxt;

  logic [srt_pkg::COUNT_W-1:0]  addr;
  logic [CW-1:0]                ch;
  logic                         count_ok;
  logic                         bad_char;

  // single read port: the sweep owns it while busy
  always_comb begin
    addr = stat.busy ? idx_r : rd_digit;
    ch   = '0;
    for (int b = 0; b < MAX_DIGITS; b++) begin
      if (addr == srt_pkg::COUNT_W'(b)) begin
        ch = alpha_r[b*CW +: CW];
      end
    end
  end

  assign rd_char   = ch;
  assign radix     = count_r;
  assign stat.busy = busy_r;
  assign stat.ok   = ok_r;

  assign count_ok = (count_r >= srt_pkg::COUNT_W'(2)) &&
                    (count_r <= srt_pkg::COUNT_W'(MAX_DIGITS));
  assign bad_char = (ch < srt_pkg::CHAR_LOW) || (ch >= srt_pkg::CHAR_HIGH) ||
                    (ch == srt_pkg::CHAR_PLUS) || (ch == srt_pkg::CHAR_MINUS) ||
                    seen_r[ch[6:0]];

  always_comb begin
    count_nxt = count_r;
    alpha_nxt = alpha_r;
    idx_nxt   = idx_r;
    seen_nxt  = seen_r;
    busy_nxt  = busy_r;
    ok_nxt    = ok_r;
    if (cfg_wr) begin
      if (cfg_idx == srt_pkg::REG_DIGIT_COUNT) begin
        count_nxt = cfg_data[srt_pkg::COUNT_W-1:0];
      end
      for (int b = 0; b < MAX_DIGITS; b++) begin
        if (cfg_idx == srt_pkg::CFG_IDX_W'(b/8) + srt_pkg::REG_ALPHA_FIRST) begin
          alpha_nxt[b*CW +: CW] = cfg_data[(b%8)*CW +: CW];
        end
      end
      // restart the sweep on any write
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      seen_nxt = '0;
      ok_nxt   = 1'b1;
    end else if (busy_r) begin
      if (!count_ok || bad_char) begin
        ok_nxt   = 1'b0;
        busy_nxt = 1'b0;
      end else begin
        seen_nxt[ch[6:0]] = 1'b1;
        if (idx_r == count_r - srt_pkg::COUNT_W'(1)) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + srt_pkg::COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= srt_pkg::DIGIT_COUNT_RESET;
      for (int b = 0; b < MAX_DIGITS; b++) begin
        alpha_r[b*CW +: CW] <= srt_pkg::alpha_reset_byte(b);
      end
      idx_r  <= '0;
      seen_r <= '0;
      busy_r <= 1'b1;
      ok_r   <= 1'b1;
    end else begin
      count_r <= count_nxt;
      alpha_r <= alpha_nxt;
      idx_r   <= idx_nxt;
      seen_r  <= seen_nxt;
      busy_r  <= busy_nxt;
      ok_r    <= ok_nxt;
    end
  end

endmodule

// File: hw/rtl/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell: one digit cell of the conversion row
// Doubles its digit plus the incoming carry modulo the radix, passes the
// carry on through a register, and shifts digits upward for output.
// ----------------------------------------------------------------------------
module srt_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [srt_pkg::COUNT_W-1:0]  radix,
  input  srt_pkg::srt_cell_ctl_t       ctl,
  input  srt_pkg::srt_link_t           link_in,
  input  logic [srt_pkg::COUNT_W-1:0]  digit_in,
  output srt_pkg::srt_link_t           link_out,
  output logic [srt_pkg::COUNT_W-1:0]  digit_out
);

  localparam int DW = srt_pkg::COUNT_W;

  logic [DW-1:0]       digit_r, digit_nxt;
  srt_pkg::srt_link_t  link_r,  link_nxt;
  logic [DW:0]         twice;
  logic                wrap;

  // digit < radix, so 2*digit + carry < 2*radix: one subtract suffices
  assign twice = {digit_r, link_in.carry};
  assign wrap  = (twice >= {1'b0, radix});

  always_comb begin
    digit_nxt = digit_r;
    link_nxt  = '0;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.shift) begin
      digit_nxt = digit_in;
    end else if (link_in.step) begin
      digit_nxt      = wrap ? DW'(twice - {1'b0, radix}) : twice[DW-1:0];
      link_nxt.step  = 1'b1;
      link_nxt.carry = wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else begin
      link_r <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign link_out  = link_r;
  assign digit_out = digit_r;

endmodule

// File: hw/rtl/srt_chain.sv
// ----------------------------------------------------------------------------
// srt_chain: row of digit cells
// Cell 0 takes the magnitude bits, most significant first; each carry moves
// one cell per cycle. The top cell holds the most significant digit.
// ----------------------------------------------------------------------------
module srt_chain #(
  parameter int VALUE_WIDTH = srt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [srt_pkg::COUNT_W-1:0]  radix,
  input  srt_pkg::srt_cell_ctl_t       ctl,
  input  srt_pkg::srt_link_t           feed,
  output logic [srt_pkg::COUNT_W-1:0]  top_digit
);

  srt_pkg::srt_link_t           link  [VALUE_WIDTH];
  logic [srt_pkg::COUNT_W-1:0]  digit [VALUE_WIDTH];

  for (genvar k = 0; k < VALUE_WIDTH; k++) begin : g_cell
    srt_pkg::srt_link_t           lin;
    logic [srt_pkg::COUNT_W-1:0]  din;

    if (k == 0) begin : g_head
      assign lin = feed;
      assign din = '0;
    end else begin : g_body
      assign lin = link[k-1];
      assign din = digit[k-1];
    end

    srt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .radix     (radix),
      .ctl       (ctl),
      .link_in   (lin),
      .digit_in  (din),
      .link_out  (link[k]),
      .digit_out (digit[k])
    );
  end

  assign top_digit = digit[VALUE_WIDTH-1];

endmodule

// File: hw/rtl/signed_int_to_custom_radix_text_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_custom_radix_text_unit: signed integer to radix text
// Writes a signed value as text in the radix of a configured alphabet,
// most significant digit first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Beat payload            | Accepted when
//  --------+-----+-------------------------+--------------------------
//  in_if   | in  | value (signed)          | valid && ready
//  out_if  | out | out_char, last          | valid && ready
//  cfg_if  | in  | index, data             | valid && ready (always ready)
//
//  One value at a time. VALUE_WIDTH bits enter cell 0, and the conversion
//  ends when the last carry reaches the top cell. Output then shifts the
//  row up one digit a cycle, unless a stalled out_if holds a character:
//  leading zero digits drop at one a cycle and each character takes one
//  beat, plus a beat for the sign of a negative value. After reset and
//  after every configuration write the alphabet checker runs one character
//  a cycle, with in_if.ready low. A stalled out_if holds its beat; the row
//  waits with it. An invalid alphabet takes the value and gives no beat.
//
module signed_int_to_custom_radix_text_unit #(
  parameter int MAX_DIGITS  = srt_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_WIDTH = srt_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  srt_in_if.sink    in_if,
  srt_out_if.source out_if,
  srt_cfg_if.sink   cfg_if
);

  localparam int CNT_W = $clog2(2*VALUE_WIDTH);
  localparam int REM_W = $clog2(VALUE_WIDTH+1);
  localparam int DW    = srt_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]               state_r,    state_nxt;
  logic [VALUE_WIDTH-1:0]   mag_r,      mag_nxt;
  logic [CNT_W-1:0]         cnt_r,      cnt_nxt;
  logic [REM_W-1:0]         rem_r,      rem_nxt;
  logic                     sign_r,     sign_nxt;
  logic                     lead_r,     lead_nxt;
  logic                     out_vld_r,  out_vld_nxt;
  logic [srt_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     in_acc;
  logic                     cfg_wr;
  logic [VALUE_WIDTH-1:0]   raw;
  logic [DW-1:0]            radix;
  logic [DW-1:0]            top_digit;
  logic [srt_pkg::CHAR_W-1:0] digit_char;
  srt_pkg::srt_alpha_stat_t astat;
  srt_pkg::srt_cell_ctl_t   cell_ctl;
  srt_pkg::srt_link_t       feed;
  logic                     slot_free;
  logic                     skip;
  logic                     emit;

  // --- handshakes ---------------------------------------------------------
  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid;
  assign in_if.ready  = (state_r == ST_IDLE) && !astat.busy;
  assign in_acc       = in_if.valid && in_if.ready;
  assign raw          = in_if.value;

  assign out_if.valid    = out_vld_r;
  assign out_if.out_char = out_char_r;
  assign out_if.last     = out_last_r;

  // --- alphabet registers, checker and lookup -----------------------------
  srt_alpha #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .cfg_idx  (cfg_if.index),
    .cfg_data (cfg_if.data),
    .rd_digit (top_digit),
    .rd_char  (digit_char),
    .radix    (radix),
    .stat     (astat)
  );

  // --- cell row -----------------------------------------------------------
  srt_chain #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .radix     (radix),
    .ctl       (cell_ctl),
    .feed      (feed),
    .top_digit (top_digit)
  );

  // Feed one magnitude bit a cycle, most significant first.
  assign feed.step  = (state_r == ST_CONV) && (cnt_r < CNT_W'(VALUE_WIDTH));
  assign feed.carry = mag_r[VALUE_WIDTH-1];

  // Drop leading zero digits without a beat; the last digit always goes out.
  assign slot_free = !out_vld_r || out_if.ready;
  assign skip      = (state_r == ST_EMIT) && lead_r && (top_digit == '0) &&
                     (rem_r != REM_W'(1));
  assign emit      = (state_r == ST_EMIT) && !sign_r && !skip && slot_free;

  assign cell_ctl.clear = in_acc;
  assign cell_ctl.shift = skip || emit;

  // --- sequencer ----------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    mag_nxt      = mag_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    sign_nxt     = sign_r;
    lead_nxt     = lead_r;
    out_vld_nxt  = out_vld_r && !out_if.ready;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && astat.ok) begin
          // two's complement magnitude; the most negative value comes out exact
          mag_nxt   = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
          sign_nxt  = raw[VALUE_WIDTH-1];
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        // last carry reaches the top cell on this cycle
        if (cnt_r == CNT_W'(2*VALUE_WIDTH-2)) begin
          rem_nxt   = REM_W'(VALUE_WIDTH);
          lead_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sign_r && slot_free) begin
          out_vld_nxt  = 1'b1;
          out_char_nxt = srt_pkg::CHAR_MINUS;
          out_last_nxt = 1'b0;
          sign_nxt     = 1'b0;
        end
        if (skip || emit) begin
          rem_nxt = rem_r - REM_W'(1);
        end
        if (emit) begin
          out_vld_nxt  = 1'b1;
          out_char_nxt = digit_char;
          out_last_nxt = (rem_r == REM_W'(1));
          lead_nxt     = 1'b0;
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      rem_r     <= '0;
      sign_r    <= 1'b0;
      lead_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      cnt_r     <= cnt_nxt;
      rem_r     <= rem_nxt;
      sign_r    <= sign_nxt;
      lead_r    <= lead_nxt;
    end
  end

  // payload: hold unless loaded
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: tb/tb_signed_int_to_custom_radix_text_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_custom_radix_text_unit: self-checking bench for radix text
// Drives signed values through the unit under a series of alphabet settings,
// valid and faulty. A scoreboard predicts every text beat and compares it.
// ----------------------------------------------------------------------------
module tb_signed_int_to_custom_radix_text_unit;

  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 250;   // conversion plus alphabet scan, with margin
  localparam int STALL_LIMIT   = 4000;  // cycles without any beat before giving up
  localparam int ALPHA_WORDS   = 7;
  localparam int ALPHA_CHARS   = 8 * ALPHA_WORDS;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers, text prediction, beat comparison
  // --------------------------------------------------------------------------
  class radix_text_scoreboard;
    logic [7:0]  char_expect_q[$];
    logic        last_expect_q[$];
    logic [5:0]  digit_count;
    logic [63:0] alpha_word[ALPHA_WORDS];
    int          errors;

    function new();
      foreach (alpha_word[k]) alpha_word[k] = '0;
      digit_count   = srt_pkg::DIGIT_COUNT_RESET;
      alpha_word[0] = srt_pkg::ALPHA_RESET_0;
      alpha_word[1] = srt_pkg::ALPHA_RESET_1;
      errors        = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [63:0] data);
      if (idx == srt_pkg::REG_DIGIT_COUNT) begin
        digit_count = data[5:0];
      end else begin
        alpha_word[idx - srt_pkg::REG_ALPHA_FIRST] = data;
      end
    endfunction

    function logic [7:0] alpha_char(input int unsigned pos);
      return alpha_word[pos / 8][(pos % 8) * 8 +: 8];
    endfunction

    // A usable alphabet: 2..MAX characters, printable, no sign, no repeats.
    function bit alphabet_ok();
      int         n;
      logic [7:0] c;
      n = int'(digit_count);
      if (n < 2 || n > srt_pkg::MAX_DIGITS_DEF) return 1'b0;
      for (int i = 0; i < n; i++) begin
        c = alpha_char(i);
        if (c < srt_pkg::CHAR_LOW || c >= srt_pkg::CHAR_HIGH ||
            c == srt_pkg::CHAR_PLUS || c == srt_pkg::CHAR_MINUS) return 1'b0;
        for (int j = i + 1; j < n; j++) begin
          if (alpha_char(j) == c) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // Work out the text of one accepted value and queue its beats.
    function void predict_text(input logic signed [31:0] value);
      logic [31:0] mag;
      logic [31:0] radix;
      logic [5:0]  digit_q[$];
      if (!alphabet_ok()) return;
      radix = 32'(digit_count);
      mag   = value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
      do begin
        digit_q.push_back(6'(mag % radix));
        mag = mag / radix;
      end while (mag != 0);
      if (value[31]) begin
        char_expect_q.push_back(srt_pkg::CHAR_MINUS);
        last_expect_q.push_back(1'b0);
      end
      for (int i = digit_q.size() - 1; i >= 0; i--) begin
        char_expect_q.push_back(alpha_char(digit_q[i]));
        last_expect_q.push_back(i == 0);
      end
    endfunction

    function void check_beat(input logic [7:0] got_char, input logic got_last);
      logic [7:0] exp_char;
      logic       exp_last;
      if (char_expect_q.size() == 0) begin
        $error("unexpected beat: out_char %02h last %0b", got_char, got_last);
        errors++;
        return;
      end
      exp_char = char_expect_q.pop_front();
      exp_last = last_expect_q.pop_front();
      if (got_char !== exp_char) begin
        $error("out_char: expected %02h, got %02h", exp_char, got_char);
        errors++;
      end
      if (got_last !== exp_last) begin
        $error("last: expected %0b, got %0b", exp_last, got_last);
        errors++;
      end
    endfunction

    function int pending();
      return char_expect_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the unit
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  logic no_idle;   // high during the stretch where neither side idles
  int   stuck_cycles;

  srt_in_if #(.VALUE_WIDTH(32)) in_if ();
  srt_out_if                    out_if ();
  srt_cfg_if                    cfg_if ();

  radix_text_scoreboard sb;

  // alphabet about to be loaded: characters and digit count
  logic [7:0] plan_chars[ALPHA_CHARS];
  logic [5:0] plan_count;

  signed_int_to_custom_radix_text_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, beat checking and the stall watchdog.
  // Sample at the edge, before the unit's own updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= 23);
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_beat(out_if.out_char, out_if.last);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Offer one value; idle first at random, hold valid until the beat is taken.
  // Valid stays high between back-to-back values, so it is never dropped and
  // raised in one step.
  task automatic send_value(input logic signed [31:0] value);
    if (!no_idle) begin
      while ($urandom_range(99) < 23) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    do @(posedge clk); while (!in_if.ready);
    sb.predict_text(value);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  // Drop the input, wait for every expected beat, then let a faulty-alphabet
  // conversion (which gives no beat) run out before touching the registers.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load the planned alphabet: count with junk in the upper bits, then all words.
  task automatic apply_plan();
    logic [63:0] word;
    write_reg(srt_pkg::REG_DIGIT_COUNT,
              ({$urandom, $urandom} & ~64'h3f) | 64'(plan_count));
    for (int k = 0; k < ALPHA_WORDS; k++) begin
      for (int b = 0; b < 8; b++) word[b*8 +: 8] = plan_chars[k*8 + b];
      write_reg(srt_pkg::REG_ALPHA_FIRST + 3'(k), word);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Shuffle the usable characters and take the first n; fill the unused
  // tail with arbitrary bytes, which the unit must not look at.
  task automatic make_valid_plan(input int n);
    logic [7:0] pool[$];
    logic [7:0] swap_char;
    int         j;
    for (int c = srt_pkg::CHAR_LOW; c < srt_pkg::CHAR_HIGH; c++) begin
      if (c != srt_pkg::CHAR_PLUS && c != srt_pkg::CHAR_MINUS) pool.push_back(8'(c));
    end
    for (int i = pool.size() - 1; i > 0; i--) begin
      j         = $urandom_range(i, 0);
      swap_char = pool[i];
      pool[i]   = pool[j];
      pool[j]   = swap_char;
    end
    for (int i = 0; i < ALPHA_CHARS; i++) begin
      plan_chars[i] = (i < n) ? pool[i] : 8'($urandom);
    end
    plan_count = 6'(n);
  endtask

  function automatic logic [7:0] pick_bad_char();
    case ($urandom_range(4))
      0:       return 8'($urandom_range(31));
      1:       return srt_pkg::CHAR_HIGH;
      2:       return 8'($urandom_range(255, 128));
      3:       return srt_pkg::CHAR_PLUS;
      default: return srt_pkg::CHAR_MINUS;
    endcase
  endfunction

  // Start from a good alphabet and break it in one of the four ways.
  task automatic make_faulty_plan();
    int n;
    int i;
    int j;
    n = $urandom_range(56, 2);
    make_valid_plan(n);
    case ($urandom_range(3))
      0: plan_count = 6'($urandom_range(1));
      1: plan_count = 6'($urandom_range(63, 57));
      2: plan_chars[$urandom_range(n - 1)] = pick_bad_char();
      default: begin
        i = $urandom_range(n - 1);
        j = $urandom_range(n - 1);
        if (i == j) j = (i + 1) % n;
        plan_chars[j] = plan_chars[i];
      end
    endcase
  endtask

  // Mix full-range values with small magnitudes, shifted ones and extremes.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6: begin
        v = $urandom_range(300);
        return $urandom_range(1) ? -v : v;
      end
      7, 8: begin
        v = $urandom;
        return v >>> $urandom_range(31);
      end
      default: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'hffff_ffff;
          3:       return 32'd1;
          default: return 32'd0;
        endcase
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] bad_chars[4];
    int         accepted_items;
    int         phase_len;

    sb = new();
    bad_chars[0] = 8'h1f;
    bad_chars[1] = srt_pkg::CHAR_HIGH;
    bad_chars[2] = srt_pkg::CHAR_PLUS;
    bad_chars[3] = srt_pkg::CHAR_MINUS;

    rst_n        <= 1'b0;
    no_idle      <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.value  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset alphabet, decimal: zero, unit values, both extremes.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'd9);
    send_value(-32'sd10);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    settle();

    // Smallest radix: longest text, the most negative value gives 33 beats.
    make_valid_plan(2);
    apply_plan();
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    settle();

    // Largest radix, every alphabet word in use.
    make_valid_plan(56);
    apply_plan();
    send_value(32'h8000_0000);
    send_value(32'd12345);
    settle();

    // Short alphabet: count of zero, then of one.
    make_valid_plan(10);
    plan_count = 6'd0;
    apply_plan();
    send_value(32'd5);
    settle();
    plan_count = 6'd1;
    apply_plan();
    send_value(-32'sd5);
    settle();

    // Count above the maximum.
    make_valid_plan(56);
    plan_count = 6'd63;
    apply_plan();
    send_value(32'd7);
    settle();

    // Bad character in the final slot: control, DEL, plus and minus.
    foreach (bad_chars[b]) begin
      make_valid_plan(16);
      plan_chars[15] = bad_chars[b];
      apply_plan();
      send_value(pick_value());
      settle();
    end

    // Repeated character, far apart.
    make_valid_plan(20);
    plan_chars[19] = plan_chars[3];
    apply_plan();
    send_value(pick_value());
    settle();

    // Random phases: mostly good alphabets of any size, some broken ones.
    // Only values under a good alphabet count towards the total.
    accepted_items = 0;
    while (accepted_items < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(99) < 80) begin
        make_valid_plan($urandom_range(56, 2));
        apply_plan();
        phase_len = $urandom_range(40, 10);
        repeat (phase_len) begin
          no_idle <= (accepted_items >= 150 && accepted_items < 250);
          send_value(pick_value());
          accepted_items++;
        end
      end else begin
        make_faulty_plan();
        apply_plan();
        phase_len = $urandom_range(5, 2);
        repeat (phase_len) send_value(pick_value());
      end
    end

    // Drain, and give the unit time to show any stray beat.
    settle();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
